/* hdl/apdu_pkg.sv */
// Shared constants for the command APDU header and length parser.
package apdu_pkg;

  // Default width of the saturating byte position counter
  localparam int unsigned PositionWidth = 17;

  // Total command lengths that select the APDU case
  localparam int unsigned LenHeaderOnly = 4;
  localparam int unsigned LenShortLe    = 5;
  localparam int unsigned LenShortLcLe  = 6;
  localparam int unsigned LenExtLe      = 7;
  localparam int unsigned LenExtMin     = 8;
  localparam int unsigned LenExtLcLe    = 9;

  // Byte positions of the header and length bytes
  localparam int unsigned PosCla = 0;
  localparam int unsigned PosIns = 1;
  localparam int unsigned PosP1  = 2;
  localparam int unsigned PosP2  = 3;
  localparam int unsigned PosB4  = 4;
  localparam int unsigned PosB5  = 5;
  localparam int unsigned PosB6  = 6;

  // Payload offset codes
  localparam logic [2:0] OffsetNone  = 3'd0;
  localparam logic [2:0] OffsetShort = 3'd5;
  localparam logic [2:0] OffsetExt   = 3'd7;

  // Le values that a zero length field stands for
  localparam logic [16:0] LeShortZero = 17'd256;
  localparam logic [16:0] LeExtZero   = 17'd65536;

endpackage

/* hdl/apdu_command_parser_unit.sv */
// Command APDU parser: collects header and length bytes, reports one result per APDU.
// A result is registered: it appears in the output register in the cycle after its last word is accepted.
// Throughput: one word per cycle; the input stalls only while the output register holds an
// untaken result and the output side is not ready.
// Reset: rst_ni clears the byte position, header and length bytes and the output valid.
// After each last word all parse state returns to zero for the next APDU.
module apdu_command_parser_unit #(
  parameter int unsigned POSITION_WIDTH = apdu_pkg::PositionWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [15:0] class_and_instruction_o,
  output logic [7:0]  param_one_o,
  output logic [7:0]  param_two_o,
  output logic [2:0]  payload_offset_o,
  output logic [15:0] payload_length_o,
  output logic [16:0] expected_length_o
);

  // Compare width: holds position plus one and the largest Lc plus nine
  localparam int unsigned CW = (POSITION_WIDTH + 1 > 18) ? POSITION_WIDTH + 1 : 18;
  localparam logic [POSITION_WIDTH-1:0] PosMax = {POSITION_WIDTH{1'b1}};

  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic [15:0] hdr_q, hdr_d;
  logic [7:0]  p1_q, p1_d;
  logic [7:0]  p2_q, p2_d;
  logic [23:0] lb_q, lb_d;
  logic [7:0]  prev_q, prev_d;

  logic        out_valid_q, out_valid_d;
  logic        status_q, status_d;
  logic [15:0] cla_ins_q, cla_ins_d;
  logic [7:0]  par1_q, par1_d;
  logic [7:0]  par2_q, par2_d;
  logic [2:0]  offset_q, offset_d;
  logic [15:0] lc_q, lc_d;
  logic [16:0] le_q, le_d;

  logic          in_fire;
  logic          saturated;
  logic [15:0]   hdr_new;
  logic [7:0]    p1_new;
  logic [7:0]    p2_new;
  logic [23:0]   lb_new;
  logic [7:0]    b4;
  logic [15:0]   b56;
  logic [15:0]   ext_word;
  logic [CW-1:0] len;
  logic          fail;
  logic [2:0]    offset;
  logic [15:0]   lc;
  logic [16:0]   le;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign saturated  = (pos_q == PosMax);

  // Capture the current word into the header and length fields by position
  always_comb begin
    hdr_new = hdr_q;
    p1_new  = p1_q;
    p2_new  = p2_q;
    lb_new  = lb_q;
    if (pos_q == POSITION_WIDTH'(apdu_pkg::PosCla)) begin
      hdr_new[15:8] = data_byte_i;
    end else if (pos_q == POSITION_WIDTH'(apdu_pkg::PosIns)) begin
      hdr_new[7:0] = data_byte_i;
    end else if (pos_q == POSITION_WIDTH'(apdu_pkg::PosP1)) begin
      p1_new = data_byte_i;
    end else if (pos_q == POSITION_WIDTH'(apdu_pkg::PosP2)) begin
      p2_new = data_byte_i;
    end else if (pos_q == POSITION_WIDTH'(apdu_pkg::PosB4)) begin
      lb_new[23:16] = data_byte_i;
    end else if (pos_q == POSITION_WIDTH'(apdu_pkg::PosB5)) begin
      lb_new[15:8] = data_byte_i;
    end else if (pos_q == POSITION_WIDTH'(apdu_pkg::PosB6)) begin
      lb_new[7:0] = data_byte_i;
    end
  end

  assign b4       = lb_new[23:16];
  assign b56      = lb_new[15:0];
  assign ext_word = {prev_q, data_byte_i};
  assign len      = CW'(pos_q) + CW'(1);

  // Classify the APDU by its total length
  always_comb begin
    fail   = 1'b0;
    offset = apdu_pkg::OffsetNone;
    lc     = 16'd0;
    le     = 17'd0;
    if (saturated || len < CW'(apdu_pkg::LenHeaderOnly)) begin
      fail = 1'b1;
    end else if (len == CW'(apdu_pkg::LenHeaderOnly)) begin
      fail = 1'b0;
    end else if (len == CW'(apdu_pkg::LenShortLe)) begin
      le = (b4 == 8'd0) ? apdu_pkg::LeShortZero : {9'd0, b4};
    end else if (b4 != 8'd0) begin
      lc     = {8'd0, b4};
      offset = apdu_pkg::OffsetShort;
      if (len == CW'(b4) + CW'(apdu_pkg::LenShortLe)) begin
        le = 17'd0;
      end else if (len == CW'(b4) + CW'(apdu_pkg::LenShortLcLe)) begin
        le = (data_byte_i == 8'd0) ? apdu_pkg::LeShortZero : {9'd0, data_byte_i};
      end else begin
        fail = 1'b1;
      end
    end else if (len == CW'(apdu_pkg::LenExtLe)) begin
      le = (b56 == 16'd0) ? apdu_pkg::LeExtZero : {1'b0, b56};
    end else if (len >= CW'(apdu_pkg::LenExtMin)) begin
      lc     = b56;
      offset = apdu_pkg::OffsetExt;
      if (len == CW'(b56) + CW'(apdu_pkg::LenExtLcLe)) begin
        le = (ext_word == 16'd0) ? apdu_pkg::LeExtZero : {1'b0, ext_word};
      end else if (len == CW'(b56) + CW'(apdu_pkg::LenExtLe)) begin
        le = 17'd0;
      end else begin
        fail = 1'b1;
      end
    end else begin
      fail = 1'b1;
    end
  end

  // Advance parse state; clear it after the last word
  always_comb begin
    pos_d  = pos_q;
    hdr_d  = hdr_q;
    p1_d   = p1_q;
    p2_d   = p2_q;
    lb_d   = lb_q;
    prev_d = prev_q;
    if (in_fire) begin
      if (last_byte_i) begin
        pos_d  = '0;
        hdr_d  = 16'd0;
        p1_d   = 8'd0;
        p2_d   = 8'd0;
        lb_d   = 24'd0;
        prev_d = 8'd0;
      end else begin
        pos_d  = saturated ? pos_q : pos_q + POSITION_WIDTH'(1);
        hdr_d  = hdr_new;
        p1_d   = p1_new;
        p2_d   = p2_new;
        lb_d   = lb_new;
        prev_d = data_byte_i;
      end
    end
  end

  // Load the result register on the last word; drop valid once taken
  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    cla_ins_d   = cla_ins_q;
    par1_d      = par1_q;
    par2_d      = par2_q;
    offset_d    = offset_q;
    lc_d        = lc_q;
    le_d        = le_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && last_byte_i) begin
      out_valid_d = 1'b1;
      status_d    = fail;
      cla_ins_d   = fail ? 16'd0 : hdr_new;
      par1_d      = fail ? 8'd0 : p1_new;
      par2_d      = fail ? 8'd0 : p2_new;
      offset_d    = fail ? apdu_pkg::OffsetNone : offset;
      lc_d        = fail ? 16'd0 : lc;
      le_d        = fail ? 17'd0 : le;
    end
  end

  // Hold parse state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hdr_q       <= 16'd0;
      p1_q        <= 8'd0;
      p2_q        <= 8'd0;
      lb_q        <= 24'd0;
      prev_q      <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      hdr_q       <= hdr_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      lb_q        <= lb_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold result payload
  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    cla_ins_q <= cla_ins_d;
    par1_q    <= par1_d;
    par2_q    <= par2_d;
    offset_q  <= offset_d;
    lc_q      <= lc_d;
    le_q      <= le_d;
  end

  assign out_valid_o             = out_valid_q;
  assign status_o                = status_q;
  assign class_and_instruction_o = cla_ins_q;
  assign param_one_o             = par1_q;
  assign param_two_o             = par2_q;
  assign payload_offset_o        = offset_q;
  assign payload_length_o        = lc_q;
  assign expected_length_o       = le_q;

endmodule

/* sim/tb_apdu_command_parser_unit.sv */
// Testbench for the command APDU parser: directed and random APDUs checked against a predictor.
module tb_apdu_command_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PosWidth   = apdu_pkg::PositionWidth;
  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned DrainWait  = 20;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic        status;
    logic [15:0] cla_ins;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [2:0]  offset;
    logic [15:0] lc;
    logic [16:0] le;
  } apdu_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        status_o;
  logic [15:0] class_and_instruction_o;
  logic [7:0]  param_one_o;
  logic [7:0]  param_two_o;
  logic [2:0]  payload_offset_o;
  logic [15:0] payload_length_o;
  logic [16:0] expected_length_o;

  // Parser state mirrored by the predictor
  logic [PosWidth-1:0] pos_q;
  logic [15:0]         hdr_word_q;
  logic [7:0]          p1_q;
  logic [7:0]          p2_q;
  logic [23:0]         len_bytes_q;
  logic [7:0]          prev_q;

  apdu_result_t pending_results[$];
  int unsigned  error_count   = 0;
  int unsigned  cycle_count   = 0;
  int unsigned  words_sent    = 0;
  int unsigned  stall_left    = 0;
  bit           idle_on       = 1'b1;
  bit           valid_up      = 1'b0;

  apdu_command_parser_unit #(
    .POSITION_WIDTH(PosWidth)
  ) u_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .data_byte_i            (data_byte_i),
    .last_byte_i            (last_byte_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .status_o               (status_o),
    .class_and_instruction_o(class_and_instruction_o),
    .param_one_o            (param_one_o),
    .param_two_o            (param_two_o),
    .payload_offset_o       (payload_offset_o),
    .payload_length_o       (payload_length_o),
    .expected_length_o      (expected_length_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    return idle_on ? $urandom_range(0, 11) : 0;
  endfunction

  // Clear the mirrored parse state
  function automatic void clear_parse();
    pos_q       = '0;
    hdr_word_q  = '0;
    p1_q        = '0;
    p2_q        = '0;
    len_bytes_q = '0;
    prev_q      = '0;
  endfunction

  // Advance the mirrored parser by one word; queue a result on the last word
  function automatic void parse_word(input logic [7:0] b, input logic is_last);
    logic         saturated;
    logic         bad;
    int unsigned  len;
    int unsigned  lc_val;
    logic [7:0]   b4;
    logic [15:0]  b56;
    logic [15:0]  le_word;
    apdu_result_t res;
    saturated = (pos_q == {PosWidth{1'b1}});
    case (int'(pos_q))
      apdu_pkg::PosCla: hdr_word_q[15:8] = b;
      apdu_pkg::PosIns: hdr_word_q[7:0] = b;
      apdu_pkg::PosP1:  p1_q = b;
      apdu_pkg::PosP2:  p2_q = b;
      apdu_pkg::PosB4:  len_bytes_q[23:16] = b;
      apdu_pkg::PosB5:  len_bytes_q[15:8] = b;
      apdu_pkg::PosB6:  len_bytes_q[7:0] = b;
      default: ;
    endcase
    if (!is_last) begin
      if (!saturated) pos_q = pos_q + 1'b1;
      prev_q = b;
      return;
    end
    len     = int'(pos_q) + 1;
    b4      = len_bytes_q[23:16];
    b56     = len_bytes_q[15:0];
    bad     = 1'b0;
    res     = '0;
    res.offset = apdu_pkg::OffsetNone;
    if (saturated || len < apdu_pkg::LenHeaderOnly) begin
      bad = 1'b1;
    end else if (len == apdu_pkg::LenHeaderOnly) begin
    end else if (len == apdu_pkg::LenShortLe) begin
      res.le = (b4 == 8'h00) ? apdu_pkg::LeShortZero : {9'd0, b4};
    end else if (b4 != 8'h00) begin
      lc_val     = b4;
      res.lc     = 16'(lc_val);
      res.offset = apdu_pkg::OffsetShort;
      if (len == lc_val + apdu_pkg::LenShortLe) begin
      end else if (len == lc_val + apdu_pkg::LenShortLcLe) begin
        res.le = (b == 8'h00) ? apdu_pkg::LeShortZero : {9'd0, b};
      end else begin
        bad = 1'b1;
      end
    end else if (len == apdu_pkg::LenExtLe) begin
      res.le = (b56 == 16'h0000) ? apdu_pkg::LeExtZero : {1'b0, b56};
    end else if (len >= apdu_pkg::LenExtMin) begin
      lc_val     = b56;
      res.lc     = b56;
      res.offset = apdu_pkg::OffsetExt;
      le_word    = {prev_q, b};
      if (len == lc_val + apdu_pkg::LenExtLcLe) begin
        res.le = (le_word == 16'h0000) ? apdu_pkg::LeExtZero : {1'b0, le_word};
      end else if (len == lc_val + apdu_pkg::LenExtLe) begin
      end else begin
        bad = 1'b1;
      end
    end else begin
      bad = 1'b1;
    end
    if (bad) begin
      res        = '0;
      res.status = 1'b1;
    end else begin
      res.cla_ins = hdr_word_q;
      res.p1      = p1_q;
      res.p2      = p2_q;
    end
    pending_results.push_back(res);
    clear_parse();
  endfunction

  // Compare one accepted result with the oldest expectation
  function automatic void check_result();
    apdu_result_t exp_res;
    if (pending_results.size() == 0) begin
      $error("unexpected result word: status %0d", status_o);
      error_count++;
      return;
    end
    exp_res = pending_results.pop_front();
    if (status_o !== exp_res.status) begin
      $error("status: expected %0d, got %0d", exp_res.status, status_o);
      error_count++;
    end
    if (class_and_instruction_o !== exp_res.cla_ins) begin
      $error("class_and_instruction: expected %h, got %h", exp_res.cla_ins,
             class_and_instruction_o);
      error_count++;
    end
    if (param_one_o !== exp_res.p1) begin
      $error("param_one: expected %h, got %h", exp_res.p1, param_one_o);
      error_count++;
    end
    if (param_two_o !== exp_res.p2) begin
      $error("param_two: expected %h, got %h", exp_res.p2, param_two_o);
      error_count++;
    end
    if (payload_offset_o !== exp_res.offset) begin
      $error("payload_offset: expected %0d, got %0d", exp_res.offset, payload_offset_o);
      error_count++;
    end
    if (payload_length_o !== exp_res.lc) begin
      $error("payload_length: expected %0d, got %0d", exp_res.lc, payload_length_o);
      error_count++;
    end
    if (expected_length_o !== exp_res.le) begin
      $error("expected_length: expected %0d, got %0d", exp_res.le, expected_length_o);
      error_count++;
    end
  endfunction

  // Take results, then hold ready low for a drawn number of cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        check_result();
        stall_left = draw_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Send one word after a drawn gap and wait for its handshake
  task automatic send_word(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      if (valid_up) in_valid_i <= 1'b0;
      valid_up = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= is_last;
    valid_up = 1'b1;
    parse_word(b, is_last);
    words_sent++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_apdu(input byte_q_t pkt);
    foreach (pkt[i]) send_word(pkt[i], i == pkt.size() - 1);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Lengths under four words fail; four words is header only
  task automatic test_header_only();
    send_apdu({8'h00});
    send_apdu({8'hFF, 8'hFF});
    send_apdu({8'h80, 8'h12, 8'h34});
    send_apdu({8'h00, 8'h00, 8'h00, 8'h00});
    send_apdu({8'hFF, 8'hFF, 8'hFF, 8'hFF});
  endtask

  // Five words: a short Le, zero meaning 256
  task automatic test_short_le();
    send_apdu({8'h00, 8'hB0, 8'h00, 8'h00, 8'h00});
    send_apdu({8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
    send_apdu({8'h00, 8'hCA, 8'h01, 8'h02, 8'h01});
  endtask

  // Short Lc with and without Le, plus a length that matches neither form
  task automatic test_short_lc();
    byte_q_t pkt;
    send_apdu({8'h00, 8'hA4, 8'h04, 8'h00, 8'h01, 8'h3F});
    send_apdu({8'h00, 8'hA4, 8'h04, 8'h00, 8'h01, 8'h3F, 8'h00});
    send_apdu({8'h00, 8'hA4, 8'h04, 8'h00, 8'h02, 8'h3F, 8'h00, 8'hFF});
    send_apdu({8'h80, 8'h10, 8'h00, 8'h00, 8'h03, 8'h01, 8'h02});
    pkt = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    repeat (255) pkt.push_back(rand_byte());
    pkt.push_back(8'hFF);
    send_apdu(pkt);
  endtask

  // Extended Le only, and six words with a zero fifth word
  task automatic test_extended_le();
    send_apdu({8'h00, 8'hB0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send_apdu({8'h00, 8'hB0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF});
    send_apdu({8'h00, 8'hB0, 8'h00, 8'h00, 8'h00, 8'h12});
  endtask

  // Extended Lc: zero Lc, optional Le word, mismatch, and the largest Lc
  task automatic test_extended_lc();
    int unsigned n;
    send_apdu({8'h00, 8'hD6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h12, 8'h34});
    send_apdu({8'h00, 8'hD6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h55});
    send_apdu({8'h00, 8'hD6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h55, 8'h00, 8'h00});
    send_apdu({8'h00, 8'hD6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'hAA, 8'h55, 8'hFF, 8'hFF});
    send_apdu({8'h00, 8'hD6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h55, 8'h00});
    // hold idling off for the long command
    idle_on = 1'b0;
    n = apdu_pkg::LenExtLe + 16'hFFFF;
    for (int unsigned i = 0; i < n; i++) begin
      case (i)
        apdu_pkg::PosB4:                  send_word(8'h00, 1'b0);
        apdu_pkg::PosB5, apdu_pkg::PosB6: send_word(8'hFF, 1'b0);
        default:                          send_word(rand_byte(), i == n - 1);
      endcase
    end
    idle_on = 1'b1;
  endtask

  // Run the position into saturation, then mark the last word
  task automatic test_oversize();
    int unsigned n;
    idle_on = 1'b0;
    n = (1 << PosWidth) + 4;
    for (int unsigned i = 0; i < n; i++) send_word(8'($urandom_range(0, 255)), 1'b0);
    send_word(8'h00, 1'b1);
    idle_on = 1'b1;
    // a normal command right after must parse cleanly
    send_apdu({8'h00, 8'hA4, 8'h04, 8'h00, 8'h01, 8'h3F, 8'h10});
  endtask

  // Mostly well-formed commands with random content, some broken or noise
  task automatic test_random();
    byte_q_t     pkt;
    int unsigned words_start;
    int unsigned lc;
    int unsigned n;
    words_start = words_sent;
    while (words_sent - words_start < 400) begin
      idle_on = ($urandom_range(0, 3) != 0);
      pkt.delete();
      repeat (4) pkt.push_back(rand_byte());
      case ($urandom_range(0, 9))
        0: ;
        1: pkt.push_back(rand_byte());
        2, 3: begin
          lc = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(1, 16);
          pkt.push_back(8'(lc));
          repeat (lc) pkt.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1)) pkt.push_back(rand_byte());
        end
        4: begin
          pkt.push_back(8'h00);
          pkt.push_back(rand_byte());
          pkt.push_back(rand_byte());
        end
        5, 6: begin
          lc = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 12);
          pkt.push_back(8'h00);
          pkt.push_back(8'(lc >> 8));
          pkt.push_back(8'(lc));
          repeat (lc) pkt.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1)) begin
            pkt.push_back(rand_byte());
            pkt.push_back(rand_byte());
          end
        end
        7: begin
          lc = $urandom_range(1, 12);
          pkt.push_back(8'(lc));
          n = $urandom_range(0, lc + 4);
          repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          pkt.delete();
          n = $urandom_range(1, 12);
          repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
        end
      endcase
      send_apdu(pkt);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    clear_parse();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_only();
    test_short_le();
    test_short_lc();
    test_extended_le();
    test_extended_lc();
    test_oversize();
    test_random();

    // Drop valid and drain the remaining results
    if (valid_up) in_valid_i <= 1'b0;
    valid_up = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
